// ===== rtl/core/sconv_pkg.sv =====
// Package for the 3x3 stencil convolution block.
// Holds field widths, register reset values, register indexes and the structs
// passed between the block's modules. Depends on nothing.
package sconv_pkg;

  localparam int PIX_W       = 8;
  localparam int ROW_W       = 12;
  localparam int OCOL_W      = 10;
  localparam int WREG_W      = 11;
  localparam int HREG_W      = 13;
  localparam int SHIFT_W     = 3;
  localparam int CIDX_W      = 3;
  localparam int KERNEL_TAPS = 9;
  localparam int WIN_TAPS    = 6;

  localparam logic [WREG_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HREG_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [HREG_W-1:0]  HEIGHT_MIN = 13'd3;
  localparam logic [HREG_W-1:0]  HEIGHT_MAX = 13'd4096;
  localparam logic [SHIFT_W-1:0] SHIFT_RST  = 3'd4;
  localparam logic [PIX_W-1:0]   PIX_MAX    = 8'd255;

  typedef enum logic [CIDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_KERNEL = 3'd2,
    CFG_SHIFT  = 3'd3,
    CFG_BORDER = 3'd4
  } cfg_idx_t;

  // Settings that do not depend on a module parameter.
  typedef struct packed {
    logic [HREG_W-1:0]  height;
    logic [SHIFT_W-1:0] shift;
    logic               border_zero;
  } cfg_t;

  // Position of one item and which results it causes.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              interior;
    logic              border;
    logic [PIX_W-1:0]  border_pix;
  } site_t;

endpackage

// ===== rtl/core/sconv_ifs.sv =====
// Valid/ready channel interfaces for the 3x3 stencil convolution block.
// Depends on sconv_pkg for the payload widths.
interface sconv_pix_if;
  logic                         valid;
  logic                         ready;
  logic [sconv_pkg::PIX_W-1:0]  pixel_in;
  logic                         frame_start;

  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink (input valid, pixel_in, frame_start, output ready);
endinterface

interface sconv_res_if;
  logic                         valid;
  logic                         ready;
  logic [sconv_pkg::ROW_W-1:0]  out_row;
  logic [sconv_pkg::OCOL_W-1:0] out_col;
  logic [sconv_pkg::PIX_W-1:0]  out_pixel;
  logic                         last_of_run;

  modport source (output valid, out_row, out_col, out_pixel, last_of_run, input ready);
  modport sink (input valid, out_row, out_col, out_pixel, last_of_run, output ready);
endinterface

// ===== rtl/core/sconv_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sconv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sconv_cfg_regs.sv =====
// Configuration registers of the 3x3 stencil convolution block, with the
// clamping of width and height to their working ranges. Depends on sconv_pkg.
module sconv_cfg_regs #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEFF_BITS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [sconv_pkg::CIDX_W-1:0] cfg_index,
  input  logic [((9*COEFF_BITS > sconv_pkg::HREG_W) ? 9*COEFF_BITS
                 : sconv_pkg::HREG_W)-1:0] cfg_wdata,
  output logic [(($clog2(MAX_WIDTH+1) > sconv_pkg::WREG_W) ? $clog2(MAX_WIDTH+1)
                 : sconv_pkg::WREG_W)-1:0] width_eff,
  output logic [9*COEFF_BITS-1:0] kernel,
  output sconv_pkg::cfg_t        cfg
);

  localparam int KW    = 9 * COEFF_BITS;
  localparam int CMP_W = ($clog2(MAX_WIDTH+1) > sconv_pkg::WREG_W) ? $clog2(MAX_WIDTH+1)
                         : sconv_pkg::WREG_W;
  // Gaussian 1 2 1 / 2 4 2 / 1 2 1, north-west weight in the lowest bits.
  localparam logic [KW-1:0] KERNEL_RST = {
    COEFF_BITS'(1), COEFF_BITS'(2), COEFF_BITS'(1),
    COEFF_BITS'(2), COEFF_BITS'(4), COEFF_BITS'(2),
    COEFF_BITS'(1), COEFF_BITS'(2), COEFF_BITS'(1)};

  logic [sconv_pkg::WREG_W-1:0]  width_reg;
  logic [sconv_pkg::HREG_W-1:0]  height_reg;
  logic [sconv_pkg::SHIFT_W-1:0] shift_reg;
  logic                          border_reg;
  logic [CMP_W-1:0]              width_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= sconv_pkg::WIDTH_RST;
      height_reg <= sconv_pkg::HEIGHT_RST;
      kernel     <= KERNEL_RST;
      shift_reg  <= sconv_pkg::SHIFT_RST;
      border_reg <= 1'b0;
    end else if (cfg_we) begin
      case (sconv_pkg::cfg_idx_t'(cfg_index))
        sconv_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[sconv_pkg::WREG_W-1:0];
        sconv_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[sconv_pkg::HREG_W-1:0];
        sconv_pkg::CFG_KERNEL: kernel     <= cfg_wdata[KW-1:0];
        sconv_pkg::CFG_SHIFT:  shift_reg  <= cfg_wdata[sconv_pkg::SHIFT_W-1:0];
        sconv_pkg::CFG_BORDER: border_reg <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign width_ext = CMP_W'(width_reg);

  always_comb begin
    if (width_ext < CMP_W'(3)) begin
      width_eff = CMP_W'(3);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end

    if (height_reg < sconv_pkg::HEIGHT_MIN) begin
      cfg.height = sconv_pkg::HEIGHT_MIN;
    end else if (height_reg > sconv_pkg::HEIGHT_MAX) begin
      cfg.height = sconv_pkg::HEIGHT_MAX;
    end else begin
      cfg.height = height_reg;
    end
    cfg.shift       = shift_reg;
    cfg.border_zero = border_reg;
  end

endmodule

// ===== rtl/core/sconv_window.sv =====
// Front end of the 3x3 stencil convolution: raster position, the two line
// stores, the six-tap window and the nine weighted taps, over two registered
// stages. Depends on sconv_pkg and sconv_ram.
module sconv_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEFF_BITS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [(($clog2(MAX_WIDTH+1) > sconv_pkg::WREG_W) ? $clog2(MAX_WIDTH+1)
                 : sconv_pkg::WREG_W)-1:0] width_eff,
  input  logic [9*COEFF_BITS-1:0] kernel,
  input  sconv_pkg::cfg_t        cfg,
  input  logic                   in_valid,
  input  logic [sconv_pkg::PIX_W-1:0] in_pixel,
  input  logic                   in_frame_start,
  output logic                   in_ready,
  input  logic                   down_ready,
  output logic                   s2_valid,
  output sconv_pkg::site_t       s2_site,
  output logic [sconv_pkg::KERNEL_TAPS-1:0][COEFF_BITS+8:0] s2_prod
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CMP_W  = ($clog2(MAX_WIDTH+1) > sconv_pkg::WREG_W) ? $clog2(MAX_WIDTH+1)
                          : sconv_pkg::WREG_W;
  localparam int PROD_W = COEFF_BITS + 9;
  localparam int PIX_W  = sconv_pkg::PIX_W;
  localparam int ROW_W  = sconv_pkg::ROW_W;
  localparam int HREG_W = sconv_pkg::HREG_W;

  // Position state.
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] r_start, r_cur;
  logic [COL_W-1:0] c_start, c_cur;
  logic             last_col, last_row;
  logic             acc;
  sconv_pkg::site_t site_new;

  // Stage one: accepted item and line store read.
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [COL_W-1:0] s1_col;
  sconv_pkg::site_t s1_site;
  logic             s1_byp;
  logic [PIX_W-1:0] byp_top, byp_mid;
  logic [PIX_W-1:0] upper_q, lower_q;
  logic [PIX_W-1:0] top, mid;
  logic             s1_fire, s2_free, byp;

  logic [PIX_W-1:0] taps [sconv_pkg::WIN_TAPS];
  logic [sconv_pkg::KERNEL_TAPS-1:0][PIX_W-1:0] nb;
  logic [sconv_pkg::KERNEL_TAPS-1:0][PROD_W-1:0] prod;

  assign s2_free  = !s2_valid || down_ready;
  assign s1_fire  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;
  assign acc      = in_valid && in_ready;

  // A start-of-frame marker or a position left outside a shrunken image
  // both put the pixel back at row or column zero.
  always_comb begin
    r_start  = in_frame_start ? '0 : row;
    c_start  = in_frame_start ? '0 : col;
    r_cur    = (HREG_W'(r_start) >= cfg.height) ? '0 : r_start;
    c_cur    = (CMP_W'(c_start) >= width_eff) ? '0 : c_start;
    last_col = CMP_W'(c_cur) == width_eff - CMP_W'(1);
    last_row = HREG_W'(r_cur) == cfg.height - HREG_W'(1);
    col_next = last_col ? '0 : c_cur + COL_W'(1);
    if (!last_col) begin
      row_next = r_cur;
    end else if (last_row) begin
      row_next = '0;
    end else begin
      row_next = r_cur + ROW_W'(1);
    end

    site_new.row        = r_cur;
    site_new.col        = sconv_pkg::OCOL_W'(c_cur);
    site_new.interior   = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    site_new.border     = (r_cur == '0) || last_row || (c_cur == '0) || last_col;
    site_new.border_pix = cfg.border_zero ? '0 : in_pixel;
  end

  // The item leaving stage one writes the column that the new item may read
  // in the same cycle; that case takes the written values instead.
  assign byp = s1_fire && (s1_col == c_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      s1_valid <= 1'b0;
      s1_byp   <= 1'b0;
    end else begin
      if (acc) begin
        row    <= row_next;
        col    <= col_next;
        s1_byp <= byp;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix  <= in_pixel;
      s1_col  <= c_cur;
      s1_site <= site_new;
      byp_top <= mid;
      byp_mid <= s1_pix;
    end
  end

  sconv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (mid),
    .re    (acc),
    .raddr (c_cur),
    .rdata (upper_q)
  );

  sconv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (acc),
    .raddr (c_cur),
    .rdata (lower_q)
  );

  assign top = s1_byp ? byp_top : upper_q;
  assign mid = s1_byp ? byp_mid : lower_q;

  always_comb begin
    nb[0] = taps[0];
    nb[1] = taps[3];
    nb[2] = top;
    nb[3] = taps[1];
    nb[4] = taps[4];
    nb[5] = mid;
    nb[6] = taps[2];
    nb[7] = taps[5];
    nb[8] = s1_pix;
    for (int k = 0; k < sconv_pkg::KERNEL_TAPS; k++) begin
      prod[k] = $signed(kernel[k*COEFF_BITS +: COEFF_BITS]) * $signed({1'b0, nb[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < sconv_pkg::WIN_TAPS; t++) begin
        taps[t] <= '0;
      end
    end else if (s1_fire) begin
      taps[0] <= taps[3];
      taps[1] <= taps[4];
      taps[2] <= taps[5];
      taps[3] <= top;
      taps[4] <= mid;
      taps[5] <= s1_pix;
    end
  end

  // Stage two: weighted taps.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_site <= s1_site;
      s2_prod <= prod;
    end
  end

  a_byp_needs_write: assert property (@(posedge clk) disable iff (rst)
    $rose(s1_byp) |-> $past(s1_fire))
    else $error("line store bypass taken without a write in the cycle before");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_free) |=> (s2_valid && $stable(s2_site)))
    else $error("stalled tap stage lost or changed its item");

endmodule

// ===== rtl/core/sconv_sum.sv =====
// Adder tree, right shift and clamp for the 3x3 stencil convolution.
// Turns the nine weighted taps into one 8-bit pixel. Depends on sconv_pkg.
module sconv_sum #(
  parameter int COEFF_BITS = 6
) (
  input  logic [sconv_pkg::KERNEL_TAPS-1:0][COEFF_BITS+8:0] prod,
  input  logic [sconv_pkg::SHIFT_W-1:0] shift,
  output logic [sconv_pkg::PIX_W-1:0]   value
);

  localparam int PROD_W = COEFF_BITS + 9;
  localparam int SUM_W  = PROD_W + 4;

  logic signed [SUM_W-1:0] sum;
  logic        [SUM_W-1:0] mag;

  always_comb begin
    sum = '0;
    for (int k = 0; k < sconv_pkg::KERNEL_TAPS; k++) begin
      sum = sum + SUM_W'($signed(prod[k]));
    end
    mag = unsigned'(sum) >> shift;
    // A sum that is zero or negative clamps to black.
    if (sum <= 0) begin
      value = '0;
    end else if (mag > SUM_W'(sconv_pkg::PIX_MAX)) begin
      value = sconv_pkg::PIX_MAX;
    end else begin
      value = mag[sconv_pkg::PIX_W-1:0];
    end
  end

endmodule

// ===== rtl/core/sconv_out.sv =====
// Result register of the 3x3 stencil convolution: holds the interior and the
// border result of one item and hands them out in order. Depends on sconv_pkg.
module sconv_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  sconv_pkg::site_t              site,
  input  logic [sconv_pkg::PIX_W-1:0]   interior_pix,
  output logic                          load_ok,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [sconv_pkg::ROW_W-1:0]   res_row,
  output logic [sconv_pkg::OCOL_W-1:0]  res_col,
  output logic [sconv_pkg::PIX_W-1:0]   res_pixel,
  output logic                          res_last
);

  logic                           int_pend, brd_pend;
  logic [sconv_pkg::ROW_W-1:0]    int_row, brd_row;
  logic [sconv_pkg::OCOL_W-1:0]   int_col, brd_col;
  logic [sconv_pkg::PIX_W-1:0]    int_pix, brd_pix;
  logic                           load, fire;

  assign res_valid = int_pend || brd_pend;
  assign res_last  = !(int_pend && brd_pend);
  assign fire      = res_valid && res_ready;
  assign load_ok   = !res_valid || (res_ready && res_last);
  assign load      = in_valid && load_ok;

  // The interior result, for the pixel up and to the left, goes first.
  assign res_row   = int_pend ? int_row : brd_row;
  assign res_col   = int_pend ? int_col : brd_col;
  assign res_pixel = int_pend ? int_pix : brd_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_pend <= 1'b0;
      brd_pend <= 1'b0;
    end else if (load) begin
      int_pend <= site.interior;
      brd_pend <= site.border;
    end else if (fire) begin
      if (int_pend) begin
        int_pend <= 1'b0;
      end else begin
        brd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      int_row <= site.row - sconv_pkg::ROW_W'(1);
      int_col <= site.col - sconv_pkg::OCOL_W'(1);
      int_pix <= interior_pix;
      brd_row <= site.row;
      brd_col <= site.col;
      brd_pix <= site.border_pix;
    end
  end

  a_second_result_kept: assert property (@(posedge clk) disable iff (rst)
    (int_pend && brd_pend && res_ready) |=> brd_pend)
    else $error("border result dropped after the interior result went out");

  a_interior_row: assert property (@(posedge clk) disable iff (rst)
    int_pend |-> (int_row != '0))
    else $error("interior result on the first row");

endmodule

// ===== rtl/core/stencil_convolution_3x3.sv =====
// Top level of the 3x3 stencil convolution over a raster stream of grey pixels.
// Depends on sconv_pkg, sconv_ifs, sconv_ram, sconv_cfg_regs, sconv_window,
// sconv_sum and sconv_out.
//
//   channel   dir   handshake      payload
//   pixels    in    valid/ready    pixel_in, frame_start
//   results   out   valid/ready    out_row, out_col, out_pixel, last_of_run
//   config    in    cfg_we         cfg_index, cfg_wdata
//
// One pixel is taken every clock while no stall on results holds the stages;
// a pixel passes the line store read, the weighted taps and the result register
// before its first result. A pixel on the last row or last column with an
// interior result ahead of it holds the result register until both are out.
// Reset (rst, synchronous) clears position, window taps and the pipeline; the
// line stores are not cleared. A stall on results backs up through the stages.
module stencil_convolution_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEFF_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sconv_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [((9*COEFF_BITS > sconv_pkg::HREG_W) ? 9*COEFF_BITS
                 : sconv_pkg::HREG_W)-1:0] cfg_wdata,
  sconv_pix_if.sink                     pixels,
  sconv_res_if.source                   results
);

  localparam int CMP_W = ($clog2(MAX_WIDTH+1) > sconv_pkg::WREG_W) ? $clog2(MAX_WIDTH+1)
                         : sconv_pkg::WREG_W;

  logic [CMP_W-1:0]               width_eff;
  logic [9*COEFF_BITS-1:0]        kernel;
  sconv_pkg::cfg_t                cfg;
  logic                           load_ok;
  logic                           s2_valid;
  sconv_pkg::site_t               s2_site;
  logic [sconv_pkg::KERNEL_TAPS-1:0][COEFF_BITS+8:0] s2_prod;
  logic [sconv_pkg::PIX_W-1:0]    interior_pix;

  sconv_cfg_regs #(.MAX_WIDTH(MAX_WIDTH), .COEFF_BITS(COEFF_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .width_eff (width_eff),
    .kernel    (kernel),
    .cfg       (cfg)
  );

  sconv_window #(.MAX_WIDTH(MAX_WIDTH), .COEFF_BITS(COEFF_BITS)) u_window (
    .clk            (clk),
    .rst            (rst),
    .width_eff      (width_eff),
    .kernel         (kernel),
    .cfg            (cfg),
    .in_valid       (pixels.valid),
    .in_pixel       (pixels.pixel_in),
    .in_frame_start (pixels.frame_start),
    .in_ready       (pixels.ready),
    .down_ready     (load_ok),
    .s2_valid       (s2_valid),
    .s2_site        (s2_site),
    .s2_prod        (s2_prod)
  );

  sconv_sum #(.COEFF_BITS(COEFF_BITS)) u_sum (
    .prod  (s2_prod),
    .shift (cfg.shift),
    .value (interior_pix)
  );

  sconv_out u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s2_valid),
    .site         (s2_site),
    .interior_pix (interior_pix),
    .load_ok      (load_ok),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_row      (results.out_row),
    .res_col      (results.out_col),
    .res_pixel    (results.out_pixel),
    .res_last     (results.last_of_run)
  );

endmodule

// ===== tb/stencil_convolution_3x3_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the 3x3 stencil convolution: follows register writes and pixel
// items, predicts every filtered pixel and compares it with the result channel.
// Depends on sconv_pkg and the channel interfaces in sconv_ifs.
module stencil_convolution_3x3_checker
  import sconv_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEFF_BITS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  cfg_idx_t                  cfg_index,
  input  logic [9*COEFF_BITS-1:0]   cfg_wdata,
  sconv_pix_if                      pix,
  sconv_res_if                      res,
  output int                        pending,
  output int                        fail_count
);

  localparam int WIDTH_MIN  = 3;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic [PIX_W-1:0]  value;
    logic              last;
  } filtered_pix_t;

  logic [WREG_W-1:0]       width_reg;
  logic [HREG_W-1:0]       height_reg;
  logic [9*COEFF_BITS-1:0] kernel_reg;
  logic [SHIFT_W-1:0]      shift_reg;
  logic                    border_zero_reg;

  logic [PIX_W-1:0] line_upper [MAX_WIDTH];
  logic [PIX_W-1:0] line_lower [MAX_WIDTH];
  logic [PIX_W-1:0] taps [WIN_TAPS];
  int unsigned      row_pos;
  int unsigned      col_pos;

  filtered_pix_t expected_px [$];
  int            mismatches = 0;

  // Works out the filtered pixels that one incoming pixel releases and moves
  // the window, line stores and raster position on by one.
  task automatic filter_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned      w, h, r, c, value;
    int               sum, wt, n;
    logic [PIX_W-1:0] top, mid;
    logic [PIX_W-1:0] nb [KERNEL_TAPS];
    filtered_pix_t    found [2];
    if (width_reg < WIDTH_MIN) w = WIDTH_MIN;
    else if (width_reg > MAX_WIDTH) w = MAX_WIDTH;
    else w = width_reg;
    if (height_reg < HEIGHT_MIN) h = HEIGHT_MIN;
    else if (height_reg > HEIGHT_MAX) h = HEIGHT_MAX;
    else h = height_reg;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    // A size change in mid-frame may leave the position outside the image.
    if (row_pos >= h) row_pos = 0;
    if (col_pos >= w) col_pos = 0;
    r = row_pos;
    c = col_pos;
    top = line_upper[c];
    mid = line_lower[c];
    n = 0;

    if (r >= 2 && c >= 2) begin
      nb[0] = taps[0]; nb[1] = taps[3]; nb[2] = top;
      nb[3] = taps[1]; nb[4] = taps[4]; nb[5] = mid;
      nb[6] = taps[2]; nb[7] = taps[5]; nb[8] = px;
      sum = 0;
      for (int k = 0; k < KERNEL_TAPS; k++) begin
        wt = $signed(kernel_reg[k*COEFF_BITS +: COEFF_BITS]);
        sum += wt * int'(nb[k]);
      end
      if (sum <= 0) begin
        value = 0;
      end else begin
        value = sum >> shift_reg;
        if (value > PIX_MAX) value = PIX_MAX;
      end
      found[n] = '{ROW_W'(r - 1), OCOL_W'(c - 1), PIX_W'(value), 1'b0};
      n++;
    end

    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
      found[n] = '{ROW_W'(r), OCOL_W'(c), border_zero_reg ? '0 : px, 1'b0};
      n++;
    end

    if (n > 0) found[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_px.push_back(found[k]);

    taps[0] = taps[3];
    taps[1] = taps[4];
    taps[2] = taps[5];
    taps[3] = top;
    taps[4] = mid;
    taps[5] = px;
    line_upper[c] = mid;
    line_lower[c] = px;

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    filtered_pix_t want;
    if (rst) begin
      width_reg       = WIDTH_RST;
      height_reg      = HEIGHT_RST;
      // Gaussian 1,2,1 / 2,4,2 / 1,2,1.
      kernel_reg      = '0;
      for (int k = 0; k < KERNEL_TAPS; k++)
        kernel_reg[k*COEFF_BITS +: COEFF_BITS] =
          COEFF_BITS'((k == 4) ? 4 : ((k % 2 == 1) ? 2 : 1));
      shift_reg       = SHIFT_RST;
      border_zero_reg = 1'b0;
      for (int k = 0; k < MAX_WIDTH; k++) begin
        line_upper[k] = '0;
        line_lower[k] = '0;
      end
      for (int k = 0; k < WIN_TAPS; k++) taps[k] = '0;
      row_pos = 0;
      col_pos = 0;
      expected_px.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_px.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("unexpected result: row %0d col %0d pixel %0d last %0b",
                     res.out_row, res.out_col, res.out_pixel, res.last_of_run);
        end else begin
          want = expected_px.pop_front();
          if (want.row !== res.out_row || want.col !== res.out_col ||
              want.value !== res.out_pixel || want.last !== res.last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
              $display({"result mismatch: expected row %0d col %0d pixel %0d last %0b,",
                        " got row %0d col %0d pixel %0d last %0b"},
                       want.row, want.col, want.value, want.last,
                       res.out_row, res.out_col, res.out_pixel, res.last_of_run);
          end
        end
      end
      if (pix.valid && pix.ready) filter_pixel(pix.pixel_in, pix.frame_start);
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg       = cfg_wdata[WREG_W-1:0];
          CFG_HEIGHT: height_reg      = cfg_wdata[HREG_W-1:0];
          CFG_KERNEL: kernel_reg      = cfg_wdata;
          CFG_SHIFT:  shift_reg       = cfg_wdata[SHIFT_W-1:0];
          CFG_BORDER: border_zero_reg = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending    <= expected_px.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/stencil_convolution_3x3_tb.sv =====
`timescale 1ns / 100ps
// Top of the 3x3 stencil convolution testbench: drives register writes and pixel
// items, paces the result side and reports the verdict.
// Depends on sconv_pkg, sconv_ifs, the block and stencil_convolution_3x3_checker.
module stencil_convolution_3x3_tb;
  import sconv_pkg::*;

  localparam int MAX_WIDTH      = 1024;
  localparam int COEFF_BITS     = 6;
  localparam int KBITS          = 9 * COEFF_BITS;
  localparam int NUM_REGS       = 5;
  localparam int RANDOM_ITEMS   = 200;
  localparam int RAND_WIDTH_MAX = 40;
  localparam int WIDE_ITEMS     = MAX_WIDTH + RAND_WIDTH_MAX;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int CYCLE_LIMIT    = 600000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  cfg_idx_t         cfg_index;
  logic [KBITS-1:0] cfg_wdata;
  int               pending;
  int               fail_count;
  int               cycle_count = 0;
  bit               src_idle_on;
  bit               res_stall_on;
  bit               hold_req;
  logic [KBITS-1:0] next_regs [NUM_REGS];

  sconv_pix_if pix_ch ();
  sconv_res_if res_ch ();

  stencil_convolution_3x3 #(
    .MAX_WIDTH (MAX_WIDTH),
    .COEFF_BITS(COEFF_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .pixels   (pix_ch),
    .results  (res_ch)
  );

  stencil_convolution_3x3_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .COEFF_BITS(COEFF_BITS)
  ) result_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pix       (pix_ch),
    .res       (res_ch),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one pixel item after a random gap and returns at the accepting edge.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_in    <= px;
    pix_ch.frame_start <= fs;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Writes the selected registers back to back; bits above each register's
  // width carry noise, which the block must ignore.
  task automatic load_regs(input logic [NUM_REGS-1:0] mask);
    logic [KBITS-1:0] keep, noise;
    int               bits;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (mask[i]) begin
        case (cfg_idx_t'(i))
          CFG_WIDTH:  bits = WREG_W;
          CFG_HEIGHT: bits = HREG_W;
          CFG_SHIFT:  bits = SHIFT_W;
          CFG_BORDER: bits = 1;
          default:    bits = KBITS;
        endcase
        keep  = (bits >= KBITS) ? '1 : ((KBITS'(1) << bits) - KBITS'(1));
        noise = KBITS'({$urandom(), $urandom()});
        cfg_we    <= 1'b1;
        cfg_index <= cfg_idx_t'(i);
        cfg_wdata <= (next_regs[i] & keep) | (noise & ~keep);
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // Stops offering pixels and waits until every predicted result has come out
  // and the pipeline is empty.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [KBITS-1:0] kernel_of(input int corner, input int side,
                                                 input int centre);
    logic [KBITS-1:0] k;
    for (int i = 0; i < 9; i++)
      k[i*COEFF_BITS +: COEFF_BITS] = COEFF_BITS'((i == 4) ? centre :
                                                  ((i % 2 == 1) ? side : corner));
    return k;
  endfunction

  function automatic logic [KBITS-1:0] random_kernel();
    logic [KBITS-1:0] k;
    int unsigned      style;
    int               wt;
    style = $urandom_range(0, 2);
    for (int i = 0; i < 9; i++) begin
      case (style)
        0:       wt = $urandom_range(0, 63);
        1:       wt = $urandom_range(0, 7);
        default: wt = int'($urandom_range(0, 16)) - 8;
      endcase
      k[i*COEFF_BITS +: COEFF_BITS] = COEFF_BITS'(wt);
    end
    return k;
  endfunction

  // Result side: a random stall after each item, and one long hold-off on request.
  initial begin : result_pacing
    int unsigned stall;
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else if (res_ch.valid && res_ch.ready) begin
        stall = res_stall_on ? $urandom_range(0, 9) : 0;
        if (stall != 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int               sent;
    int               n_items;
    bit               fresh;
    logic [PIX_W-1:0] px;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_WIDTH;
    cfg_wdata          <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel_in    <= '0;
    pix_ch.frame_start <= 1'b0;
    src_idle_on  = 1'b1;
    res_stall_on = 1'b1;
    hold_req     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the first row passes straight through.
    send_pixel('0, 1'b0);
    send_pixel(PIX_MAX, 1'b0);
    settle();

    // Smallest image from a too-small size, identity kernel, zeroed border.
    next_regs[CFG_WIDTH]  = KBITS'(2);
    next_regs[CFG_HEIGHT] = KBITS'(0);
    next_regs[CFG_KERNEL] = kernel_of(0, 0, 1);
    next_regs[CFG_SHIFT]  = KBITS'(0);
    next_regs[CFG_BORDER] = KBITS'(1);
    load_regs('1);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? PIX_W'(200) : PIX_W'($urandom), i == 0);
    settle();

    // Largest weights on a white frame: the sum saturates at the top.
    next_regs[CFG_WIDTH]  = KBITS'(1);
    next_regs[CFG_HEIGHT] = KBITS'(2);
    next_regs[CFG_KERNEL] = kernel_of(31, 31, 31);
    next_regs[CFG_SHIFT]  = KBITS'(7);
    next_regs[CFG_BORDER] = KBITS'(0);
    load_regs('1);
    for (int i = 0; i < 9; i++) send_pixel(PIX_MAX, i == 0);
    settle();

    // Most negative weights: the sum goes below zero and gives black.
    next_regs[CFG_WIDTH]  = KBITS'(3);
    next_regs[CFG_HEIGHT] = KBITS'(3);
    next_regs[CFG_KERNEL] = kernel_of(-32, -32, -32);
    next_regs[CFG_SHIFT]  = KBITS'(0);
    load_regs('1);
    for (int i = 0; i < 9; i++) send_pixel(PIX_W'($urandom_range(1, 255)), i == 0);
    settle();

    // Widest rows and tallest frame. One full row and the start of the next
    // write every column that the later, narrower images use into both line
    // stores, so later size changes in mid-frame never read an unwritten entry.
    next_regs[CFG_WIDTH]  = KBITS'(2047);
    next_regs[CFG_HEIGHT] = KBITS'(8191);
    next_regs[CFG_KERNEL] = random_kernel();
    next_regs[CFG_SHIFT]  = KBITS'($urandom_range(0, 7));
    next_regs[CFG_BORDER] = KBITS'($urandom_range(0, 1));
    load_regs('1);
    src_idle_on  = 1'b0;
    res_stall_on = 1'b1;
    for (int i = 0; i < WIDE_ITEMS; i++) begin
      if (i == 300) hold_req = 1'b1;
      send_pixel(PIX_W'($urandom), i == 0);
    end
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       next_regs[CFG_WIDTH] = KBITS'($urandom_range(0, 2));
        1:       next_regs[CFG_WIDTH] = KBITS'($urandom_range(13, RAND_WIDTH_MAX));
        default: next_regs[CFG_WIDTH] = KBITS'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 6))
        0:       next_regs[CFG_HEIGHT] = KBITS'($urandom_range(0, 2));
        1:       next_regs[CFG_HEIGHT] = KBITS'($urandom_range(9, 8191));
        default: next_regs[CFG_HEIGHT] = KBITS'($urandom_range(3, 8));
      endcase
      next_regs[CFG_KERNEL] = random_kernel();
      next_regs[CFG_SHIFT]  = KBITS'($urandom_range(0, 7));
      next_regs[CFG_BORDER] = KBITS'($urandom_range(0, 1));
      load_regs(NUM_REGS'($urandom_range(1, 31)));
      src_idle_on  = ($urandom_range(0, 3) != 0);
      res_stall_on = ($urandom_range(0, 3) != 0);
      // Without a frame start the stream carries on from where it stood, so a
      // smaller size may leave the position outside the image.
      fresh   = ($urandom_range(0, 3) != 0);
      n_items = $urandom_range(10, 60);
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 9))
          0:       px = '0;
          1:       px = PIX_MAX;
          default: px = PIX_W'($urandom);
        endcase
        send_pixel(px, (i == 0 && fresh) || ($urandom_range(0, 59) == 0));
      end
      sent += n_items;
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== stencil_convolution_3x3.f =====
rtl/core/sconv_pkg.sv
rtl/core/sconv_ifs.sv
rtl/core/sconv_ram.sv
rtl/core/sconv_cfg_regs.sv
rtl/core/sconv_window.sv
rtl/core/sconv_sum.sv
rtl/core/sconv_out.sv
rtl/core/stencil_convolution_3x3.sv
tb/stencil_convolution_3x3_checker.sv
tb/stencil_convolution_3x3_tb.sv
